>>> design/drfp_pkg.sv
`timescale 1ns / 1ps

package drfp_pkg;

  // Frame layout
  localparam int unsigned MaxParams = 4;
  localparam int unsigned ParamIdxW = $clog2(MaxParams);
  localparam int unsigned CountW    = $clog2(MaxParams + 1);

  localparam logic [7:0] HdrByte = 8'hF2;
  localparam logic [7:0] EndByte = 8'h7E;

  // Response commands
  localparam logic [7:0] RspHeight = 8'h01;
  localparam logic [7:0] RspPhys   = 8'h07;
  localparam logic [7:0] RspFlags  = 8'h20;
  localparam logic [7:0] RspMax    = 8'h21;
  localparam logic [7:0] RspMin    = 8'h22;

  // Flag bits in the first parameter of a flags response
  localparam logic [7:0] FlagMax = 8'h01;
  localparam logic [7:0] FlagMin = 8'h10;

  // Header bytes before the command
  localparam logic [3:0] HdrCount = 4'd2;

  typedef enum logic [2:0] {
    StInProgress = 3'd0,
    StFrameOk    = 3'd1,
    StBadHeader  = 3'd2,
    StBadLength  = 3'd3,
    StBadSum     = 3'd4,
    StBadEnd     = 3'd5
  } status_e;

  typedef enum logic [5:0] {
    PhHeader  = 6'b000001,
    PhCommand = 6'b000010,
    PhLength  = 6'b000100,
    PhParams  = 6'b001000,
    PhSum     = 6'b010000,
    PhEnd     = 6'b100000
  } phase_e;

  // What the framer reports for the byte being taken
  typedef struct packed {
    logic                            ok;
    status_e                         status;
    logic [7:0]                      cmd;
    logic [CountW-1:0]               count;
    logic [MaxParams-1:0][7:0]       params;
  } frame_t;

endpackage

>>> design/drfp_framer.sv
`timescale 1ns / 1ps

module drfp_framer import drfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  output frame_t     frame_o
);

  phase_e                    phase_q, phase_d;
  logic [3:0]                idx_q, idx_d;
  logic [CountW-1:0]         count_q, count_d;
  logic [7:0]                sum_q, sum_d;
  logic [7:0]                cmd_q, cmd_d;
  logic [MaxParams-1:0][7:0] params_q;
  logic                      param_we;
  logic [3:0]                idx_inc;
  status_e                   status;
  logic                      ok;

  assign idx_inc = idx_q + 4'd1;

  // Next-state logic for one byte
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    count_d  = count_q;
    sum_d    = sum_q;
    cmd_d    = cmd_q;
    param_we = 1'b0;
    status   = StInProgress;
    ok       = 1'b0;
    case (phase_q)
      PhHeader: begin
        if (rx_byte_i != HdrByte) begin
          status  = StBadHeader;
          phase_d = PhHeader;
          idx_d   = '0;
          count_d = '0;
          sum_d   = '0;
        end else begin
          idx_d = idx_inc;
          if (idx_inc >= HdrCount) phase_d = PhCommand;
        end
      end
      PhCommand: begin
        cmd_d   = rx_byte_i;
        sum_d   = rx_byte_i;
        phase_d = PhLength;
      end
      PhLength: begin
        if (rx_byte_i > 8'(MaxParams)) begin
          status  = StBadLength;
          phase_d = PhHeader;
          idx_d   = '0;
          count_d = '0;
          sum_d   = '0;
        end else begin
          count_d = rx_byte_i[CountW-1:0];
          idx_d   = '0;
          sum_d   = sum_q + rx_byte_i;
          phase_d = (rx_byte_i != 8'd0) ? PhParams : PhSum;
        end
      end
      PhParams: begin
        param_we = 1'b1;
        sum_d    = sum_q + rx_byte_i;
        idx_d    = idx_inc;
        if (idx_inc >= 4'(count_q)) phase_d = PhSum;
      end
      PhSum: begin
        if (rx_byte_i != sum_q) begin
          status  = StBadSum;
          phase_d = PhHeader;
          idx_d   = '0;
          count_d = '0;
          sum_d   = '0;
        end else begin
          phase_d = PhEnd;
        end
      end
      PhEnd: begin
        if (rx_byte_i == EndByte) begin
          status = StFrameOk;
          ok     = 1'b1;
        end else begin
          status = StBadEnd;
        end
        phase_d = PhHeader;
        idx_d   = '0;
        count_d = '0;
        sum_d   = '0;
      end
      default: begin
        phase_d = PhHeader;
        idx_d   = '0;
        count_d = '0;
        sum_d   = '0;
      end
    endcase
  end

  // Parse control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      idx_q   <= '0;
      count_q <= '0;
      sum_q   <= '0;
      cmd_q   <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      cmd_q   <= cmd_d;
    end
  end

  // Parameter bytes of the current frame
  always_ff @(posedge clk_i) begin
    if (take_i && param_we) begin
      params_q[idx_q[ParamIdxW-1:0]] <= rx_byte_i;
    end
  end

  assign frame_o.ok     = ok;
  assign frame_o.status = status;
  assign frame_o.cmd    = cmd_q;
  assign frame_o.count  = count_q;
  assign frame_o.params = params_q;

endmodule

>>> design/desk_response_frame_parser.sv
`timescale 1ns / 1ps

// Response frame parser for a standing-desk controller. Takes one received
// serial byte per item and returns exactly one result item per byte: a
// status (in progress, frame ok, or the kind of framing error), the command
// of a completed good frame, and the current desk height, physical limits
// and configured limits, which change only when a good frame decodes. A
// byte is taken in every cycle that the result register is empty or being
// drained in the same cycle, so the block sustains one byte per clock; the
// result of a byte shows in the cycle after it is taken; request_limits is
// high only on the result that completes a valid physical limits frame.
module desk_response_frame_parser import drfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [7:0]  response_code_o,
  output logic [15:0] height_o,
  output logic        height_valid_o,
  output logic [15:0] phys_max_o,
  output logic [15:0] phys_min_o,
  output logic [15:0] cfg_max_o,
  output logic        cfg_max_valid_o,
  output logic [15:0] cfg_min_o,
  output logic        cfg_min_valid_o,
  output logic        request_limits_o
);

  frame_t      frame;
  logic        take;

  logic        out_valid_q;
  status_e     status_q;
  logic [7:0]  code_q, code_d;
  logic        req_q, req_d;
  logic [15:0] height_q, height_d;
  logic        height_valid_q, height_valid_d;
  logic [15:0] phys_max_q, phys_max_d;
  logic [15:0] phys_min_q, phys_min_d;
  logic [15:0] cfg_max_q, cfg_max_d;
  logic        cfg_max_valid_q, cfg_max_valid_d;
  logic [15:0] cfg_min_q, cfg_min_d;
  logic        cfg_min_valid_q, cfg_min_valid_d;
  logic [15:0] pair0, pair2;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  drfp_framer u_framer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (take),
    .rx_byte_i(rx_byte_i),
    .frame_o  (frame)
  );

  assign pair0 = {frame.params[0], frame.params[1]};
  assign pair2 = {frame.params[2], frame.params[3]};

  // Decode a completed good frame
  always_comb begin
    code_d          = 8'd0;
    req_d           = 1'b0;
    height_d        = height_q;
    height_valid_d  = height_valid_q;
    phys_max_d      = phys_max_q;
    phys_min_d      = phys_min_q;
    cfg_max_d       = cfg_max_q;
    cfg_max_valid_d = cfg_max_valid_q;
    cfg_min_d       = cfg_min_q;
    cfg_min_valid_d = cfg_min_valid_q;
    if (frame.ok) begin
      code_d = frame.cmd;
      case (frame.cmd)
        RspHeight: begin
          if (frame.count == CountW'(3)) begin
            height_d       = pair0;
            height_valid_d = 1'b1;
          end
        end
        RspPhys: begin
          if (frame.count == CountW'(4)) begin
            phys_max_d = pair0;
            phys_min_d = pair2;
            req_d      = 1'b1;
          end
        end
        RspFlags: begin
          // empty flags frame carries nothing to apply
          if (frame.count != '0) begin
            if ((frame.params[0] & FlagMax) == 8'd0) begin
              cfg_max_d       = '0;
              cfg_max_valid_d = 1'b0;
            end
            if ((frame.params[0] & FlagMin) == 8'd0) begin
              cfg_min_d       = '0;
              cfg_min_valid_d = 1'b0;
            end
          end
        end
        RspMax: begin
          if (frame.count == CountW'(2)) begin
            cfg_max_d       = pair0;
            cfg_max_valid_d = 1'b1;
          end
        end
        RspMin: begin
          if (frame.count == CountW'(2)) begin
            cfg_min_d       = pair0;
            cfg_min_valid_d = 1'b1;
          end
        end
        default: begin
          code_d = frame.cmd;
        end
      endcase
    end
  end

  // Result register; stored desk values double as result fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q     <= 1'b0;
      status_q        <= StInProgress;
      code_q          <= '0;
      req_q           <= 1'b0;
      height_q        <= '0;
      height_valid_q  <= 1'b0;
      phys_max_q      <= '0;
      phys_min_q      <= '0;
      cfg_max_q       <= '0;
      cfg_max_valid_q <= 1'b0;
      cfg_min_q       <= '0;
      cfg_min_valid_q <= 1'b0;
    end else begin
      if (take) begin
        out_valid_q     <= 1'b1;
        status_q        <= frame.status;
        code_q          <= code_d;
        req_q           <= req_d;
        height_q        <= height_d;
        height_valid_q  <= height_valid_d;
        phys_max_q      <= phys_max_d;
        phys_min_q      <= phys_min_d;
        cfg_max_q       <= cfg_max_d;
        cfg_max_valid_q <= cfg_max_valid_d;
        cfg_min_q       <= cfg_min_d;
        cfg_min_valid_q <= cfg_min_valid_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign response_code_o  = code_q;
  assign height_o         = height_q;
  assign height_valid_o   = height_valid_q;
  assign phys_max_o       = phys_max_q;
  assign phys_min_o       = phys_min_q;
  assign cfg_max_o        = cfg_max_q;
  assign cfg_max_valid_o  = cfg_max_valid_q;
  assign cfg_min_o        = cfg_min_q;
  assign cfg_min_valid_o  = cfg_min_valid_q;
  assign request_limits_o = req_q;

endmodule

>>> dv/tb_desk_response_frame_parser.sv
`timescale 1ns / 1ps

module tb_desk_response_frame_parser;
  import drfp_pkg::*;

  // One result item as the parser reports it
  typedef struct {
    status_e     status;
    logic [7:0]  code;
    logic [15:0] height;
    logic        height_ok;
    logic [15:0] phys_max;
    logic [15:0] phys_min;
    logic [15:0] cfg_max;
    logic        cfg_max_ok;
    logic [15:0] cfg_min;
    logic        cfg_min_ok;
    logic        req_limits;
  } desk_readout_t;

  // Ways a generated frame may be broken after its length byte
  typedef enum int {
    FlawNone,
    FlawSum,
    FlawEnd
  } frame_flaw_e;

  localparam int unsigned RandomBytes = 650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  response_code_o;
  logic [15:0] height_o;
  logic        height_valid_o;
  logic [15:0] phys_max_o;
  logic [15:0] phys_min_o;
  logic [15:0] cfg_max_o;
  logic        cfg_max_valid_o;
  logic [15:0] cfg_min_o;
  logic        cfg_min_valid_o;
  logic        request_limits_o;

  desk_response_frame_parser DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .response_code_o  (response_code_o),
    .height_o         (height_o),
    .height_valid_o   (height_valid_o),
    .phys_max_o       (phys_max_o),
    .phys_min_o       (phys_min_o),
    .cfg_max_o        (cfg_max_o),
    .cfg_max_valid_o  (cfg_max_valid_o),
    .cfg_min_o        (cfg_min_o),
    .cfg_min_valid_o  (cfg_min_valid_o),
    .request_limits_o (request_limits_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Parser state mirrored on the testbench side
  phase_e      seek_phase;
  logic [3:0]  hdr_seen;
  logic [2:0]  frame_len;
  logic [7:0]  frame_sum;
  logic [7:0]  frame_cmd;
  logic [7:0]  frame_params [MaxParams];
  logic [15:0] desk_height;
  logic        desk_height_ok;
  logic [15:0] phys_max_lim;
  logic [15:0] phys_min_lim;
  logic [15:0] cfg_max_lim;
  logic        cfg_max_set;
  logic [15:0] cfg_min_lim;
  logic        cfg_min_set;

  desk_readout_t expected_readouts [$];
  int unsigned   mismatch_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   burst_left = 0;

  function automatic void restart_frame();
    seek_phase = PhHeader;
    hdr_seen   = '0;
    frame_len  = '0;
    frame_sum  = '0;
  endfunction

  function automatic void clear_desk_state();
    restart_frame();
    frame_cmd      = '0;
    desk_height    = '0;
    desk_height_ok = 1'b0;
    phys_max_lim   = '0;
    phys_min_lim   = '0;
    cfg_max_lim    = '0;
    cfg_max_set    = 1'b0;
    cfg_min_lim    = '0;
    cfg_min_set    = 1'b0;
  endfunction

  // Advance the mirrored parser by one byte and return what it must report
  function automatic desk_readout_t frame_step(input logic [7:0] b);
    desk_readout_t r;
    r.status     = StInProgress;
    r.code       = '0;
    r.req_limits = 1'b0;
    case (seek_phase)
      PhHeader: begin
        if (b != HdrByte) begin
          restart_frame();
          r.status = StBadHeader;
        end else begin
          hdr_seen = hdr_seen + 1'b1;
          if (hdr_seen >= HdrCount) seek_phase = PhCommand;
        end
      end
      PhCommand: begin
        frame_cmd  = b;
        frame_sum  = b;
        seek_phase = PhLength;
      end
      PhLength: begin
        if (b > MaxParams) begin
          restart_frame();
          r.status = StBadLength;
        end else begin
          frame_len  = b[2:0];
          hdr_seen   = '0;
          frame_sum  = frame_sum + b;
          seek_phase = (b != 8'd0) ? PhParams : PhSum;
        end
      end
      PhParams: begin
        frame_params[hdr_seen[ParamIdxW-1:0]] = b;
        frame_sum = frame_sum + b;
        hdr_seen  = hdr_seen + 1'b1;
        if (hdr_seen >= frame_len) seek_phase = PhSum;
      end
      PhSum: begin
        if (b != frame_sum) begin
          restart_frame();
          r.status = StBadSum;
        end else begin
          seek_phase = PhEnd;
        end
      end
      default: begin
        if (b == EndByte) begin
          r.status = StFrameOk;
          r.code   = frame_cmd;
          // decode; a length that does not fit the command changes nothing
          case (frame_cmd)
            RspHeight: if (frame_len == 3'd3) begin
              desk_height    = {frame_params[0], frame_params[1]};
              desk_height_ok = 1'b1;
            end
            RspPhys: if (frame_len == 3'd4) begin
              phys_max_lim = {frame_params[0], frame_params[1]};
              phys_min_lim = {frame_params[2], frame_params[3]};
              r.req_limits = 1'b1;
            end
            RspFlags: if (frame_len >= 3'd1) begin
              if ((frame_params[0] & FlagMax) == 8'h00) begin
                cfg_max_set = 1'b0;
                cfg_max_lim = '0;
              end
              if ((frame_params[0] & FlagMin) == 8'h00) begin
                cfg_min_set = 1'b0;
                cfg_min_lim = '0;
              end
            end
            RspMax: if (frame_len == 3'd2) begin
              cfg_max_lim = {frame_params[0], frame_params[1]};
              cfg_max_set = 1'b1;
            end
            RspMin: if (frame_len == 3'd2) begin
              cfg_min_lim = {frame_params[0], frame_params[1]};
              cfg_min_set = 1'b1;
            end
            default: ;
          endcase
        end else begin
          r.status = StBadEnd;
        end
        restart_frame();
      end
    endcase
    r.height     = desk_height;
    r.height_ok  = desk_height_ok;
    r.phys_max   = phys_max_lim;
    r.phys_min   = phys_min_lim;
    r.cfg_max    = cfg_max_lim;
    r.cfg_max_ok = cfg_max_set;
    r.cfg_min    = cfg_min_lim;
    r.cfg_min_ok = cfg_min_set;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch: got %h, want %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // Send one byte; the sender works in bursts with idle gaps between them
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readouts.push_back(frame_step(b));
    bytes_sent++;
    burst_left--;
  endtask

  // Hold off the sender until every pending result has drained
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_readouts.size() != 0);
    burst_left = 0;
  endtask

  // params carries p0 in its top byte
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [31:0] params, input frame_flaw_e flaw);
    logic [7:0] sum;
    logic [7:0] spoil;
    int         i;
    send_byte(HdrByte);
    send_byte(HdrByte);
    send_byte(cmd);
    send_byte(len);
    if (len > MaxParams) return;
    sum = cmd + len;
    for (i = 0; i < len; i++) begin
      send_byte(params[8*(3-i) +: 8]);
      sum = sum + params[8*(3-i) +: 8];
    end
    spoil = 8'($urandom_range(1, 255));
    send_byte((flaw == FlawSum) ? (sum ^ spoil) : sum);
    if (flaw == FlawSum) return;
    send_byte((flaw == FlawEnd) ? (EndByte ^ spoil) : EndByte);
  endtask

  // Parameter bytes lean toward the extremes
  function automatic logic [7:0] pick_param();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Stray byte, bad length, bad checksum, bad end marker
  task automatic test_error_paths();
    send_byte(8'h00);
    send_frame(RspMax, 8'd5, 32'h0, FlawNone);
    send_frame(RspMin, 8'd0, 32'h0, FlawSum);
    send_frame(RspFlags, 8'd0, 32'h0, FlawEnd);
  endtask

  // Largest configured max, then a flags frame of length zero that must be ignored
  task automatic test_limit_frames();
    send_frame(RspMax, 8'd2, 32'hFFFF_0000, FlawNone);
    send_frame(RspFlags, 8'd0, 32'h0, FlawNone);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken ones
  task automatic test_random_stream();
    logic [7:0]  cmd;
    logic [7:0]  len;
    logic [31:0] params;
    frame_flaw_e flaw;
    while (bytes_sent < RandomBytes) begin
      case ($urandom_range(0, 19))
        0, 1: begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
        2: begin
          send_byte(HdrByte);
          send_byte(8'($urandom_range(0, 255)));
        end
        default: begin
          case ($urandom_range(0, 5))
            0: begin cmd = RspHeight; len = 8'd3; end
            1: begin cmd = RspPhys;   len = 8'd4; end
            2: begin cmd = RspFlags;  len = 8'($urandom_range(1, MaxParams)); end
            3: begin cmd = RspMax;    len = 8'd2; end
            4: begin cmd = RspMin;    len = 8'd2; end
            default: begin
              cmd = 8'($urandom_range(0, 255));
              len = 8'($urandom_range(0, MaxParams));
            end
          endcase
          case ($urandom_range(0, 19))
            0, 1, 2: len = 8'($urandom_range(0, MaxParams));
            3: len = 8'($urandom_range(MaxParams + 1, 255));
            default: ;
          endcase
          params = {pick_param(), pick_param(), pick_param(), pick_param()};
          case ($urandom_range(0, 19))
            0, 1: flaw = FlawSum;
            2, 3: flaw = FlawEnd;
            default: flaw = FlawNone;
          endcase
          send_frame(cmd, len, params, flaw);
        end
      endcase
    end
  endtask

  // Receiver stalls in stretches of different character
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned rx_cycle = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    rx_cycle++;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (rx_cycle % 3 != 0);
    endcase
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk_i) begin : check_results
    desk_readout_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readouts.size() == 0) begin
        report_mismatch("unexpected result", 16'(status_o), 16'h0);
      end else begin
        want = expected_readouts.pop_front();
        if (status_o !== want.status)
          report_mismatch("status", 16'(status_o), 16'(want.status));
        if (response_code_o !== want.code)
          report_mismatch("response_code", 16'(response_code_o), 16'(want.code));
        if (height_o !== want.height) report_mismatch("height", height_o, want.height);
        if (height_valid_o !== want.height_ok)
          report_mismatch("height_valid", 16'(height_valid_o), 16'(want.height_ok));
        if (phys_max_o !== want.phys_max)
          report_mismatch("phys_max", phys_max_o, want.phys_max);
        if (phys_min_o !== want.phys_min)
          report_mismatch("phys_min", phys_min_o, want.phys_min);
        if (cfg_max_o !== want.cfg_max) report_mismatch("cfg_max", cfg_max_o, want.cfg_max);
        if (cfg_max_valid_o !== want.cfg_max_ok)
          report_mismatch("cfg_max_valid", 16'(cfg_max_valid_o), 16'(want.cfg_max_ok));
        if (cfg_min_o !== want.cfg_min) report_mismatch("cfg_min", cfg_min_o, want.cfg_min);
        if (cfg_min_valid_o !== want.cfg_min_ok)
          report_mismatch("cfg_min_valid", 16'(cfg_min_valid_o), 16'(want.cfg_min_ok));
        if (request_limits_o !== want.req_limits)
          report_mismatch("request_limits", 16'(request_limits_o), 16'(want.req_limits));
      end
    end
  end

  initial begin : run_tests
    int unsigned waited;
    clear_desk_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_error_paths();
    test_limit_frames();
    drain_results();
    test_random_stream();
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_readouts.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0 && expected_readouts.size() == 0) begin
      $display("tb_desk_response_frame_parser OK");
    end else begin
      $display("tb_desk_response_frame_parser NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_desk_response_frame_parser NOT OK");
    $finish;
  end

endmodule
